// ===== rtl/core/adl_pkg.sv =====
package adl_pkg;

	localparam int ALPHABET = 26;
	localparam int LETTER_W = 5;
	localparam int STATUS_W = 2;
	localparam int MAX_WORDS_DEF = 256;
	localparam int COUNT_BITS_DEF = 6;

	typedef enum logic [STATUS_W-1:0] {
		ST_NO_MATCH = 2'd0,
		ST_MATCH    = 2'd1,
		ST_STORED   = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_SEARCH = 1'b1
	} state_t;

endpackage

// ===== rtl/core/anagram_dictionary_lookup_top.sv =====
// Anagram lookup by letter histogram.
// Input channel (in_valid / in_stall): one letter per transaction, with
// req_type (0 dictionary, 1 query) and last_letter marking the end of a word.
// Output channel (out_valid / out_stall): one status transaction per finished
// word: 0 query no match, 1 query match, 2 word stored, 3 table full, dropped.
// Letters that do not end a word only update the histogram and give no result.
// The status of the last letter of a dictionary word is shown the cycle
// after acceptance.
// The last letter of a query starts a walk over the stored words through the
// single read port of the word table, one word per cycle. The walk reads
// every stored word when no word matches and ends early on a match; status
// appears the cycle after the walk ends. No letter is taken during the walk.
// A pending status held by out_stall blocks further letters until taken.
// Reset clears the histogram, the stored word count and the output register;
// the table needs no clearing pass since only stored entries are read.
module anagram_dictionary_lookup_top
	import adl_pkg::*;
#(
	parameter int MAX_WORDS  = adl_pkg::MAX_WORDS_DEF,
	parameter int COUNT_BITS = adl_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [adl_pkg::LETTER_W-1:0]  letter,
	input  logic                          last_letter,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [adl_pkg::STATUS_W-1:0]  status
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int RW = ALPHABET * COUNT_BITS;

	typedef logic [ALPHABET-1:0][COUNT_BITS-1:0] hist_t;

	state_t           state_q, state_d;
	hist_t            hist_q, hist_d;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ptr_q;
	logic             cmp_vld_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic             in_acc;
	logic             issue;
	logic             hit;
	logic             search_done;
	logic             not_full;
	logic             mem_we;
	logic [RW-1:0]    rdata;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign not_full = count_q < CW'(MAX_WORDS);
	assign issue    = (state_q == S_SEARCH) && (ptr_q < count_q);
	assign hit      = cmp_vld_q && (rdata == RW'(hist_q));
	assign mem_we   = in_acc && last_letter && !req_type && not_full;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;

	always_comb begin
		for (int i = 0; i < ALPHABET; i++) begin
			hist_d[i] = hist_q[i];
			if (letter == LETTER_W'(i) && hist_q[i] != {COUNT_BITS{1'b1}}) begin
				hist_d[i] = hist_q[i] + COUNT_BITS'(1);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		search_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && last_letter && req_type) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (hit || (!issue && !cmp_vld_q)) begin
					search_done = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q       <= '0;
			count_q      <= '0;
			ptr_q        <= '0;
			cmp_vld_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_NO_MATCH;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				hist_q <= hist_d;
				if (last_letter) begin
					ptr_q     <= '0;
					cmp_vld_q <= 1'b0;
					if (!req_type) begin
						hist_q      <= '0;
						out_valid_q <= 1'b1;
						if (not_full) begin
							count_q      <= count_q + CW'(1);
							out_status_q <= ST_STORED;
						end else begin
							out_status_q <= ST_FULL;
						end
					end
				end
			end
			if (state_q == S_SEARCH) begin
				cmp_vld_q <= issue;
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (search_done) begin
				hist_q       <= '0;
				cmp_vld_q    <= 1'b0;
				out_valid_q  <= 1'b1;
				out_status_q <= hit ? ST_MATCH : ST_NO_MATCH;
			end
		end
	end

	adl_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_WORDS),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(RW'(hist_d)),
		.re   (issue),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	a_no_accept_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> in_stall)
		else $error("letter accepted during table walk");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WORDS))
		else $error("stored word count beyond table depth");

	a_done_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		search_done |=> (out_valid_q && (out_status_q == ST_MATCH ||
			out_status_q == ST_NO_MATCH)))
		else $error("finished query gave no query status");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE && !(out_valid_q && out_stall)))
		else $error("table write outside idle");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (ptr_q <= count_q))
		else $error("walk pointer past stored words");

endmodule

// ===== rtl/core/adl_ram.sv =====
module adl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	import adl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WORDS = adl_pkg::MAX_WORDS_DEF;
	localparam int COUNT_W   = adl_pkg::COUNT_BITS_DEF;
	localparam int WORD_MAX  = 8;
	localparam bit REQ_DICT  = 1'b0;
	localparam bit REQ_QUERY = 1'b1;
	localparam bit [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef bit [ALPHABET-1:0][COUNT_W-1:0] hist_t;
	typedef struct {
		letter_t l [WORD_MAX];
		int      n;
	} word_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                req_type = 1'b0;
	letter_t             letter = '0;
	logic                last_letter = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;

	hist_t       letter_hist;
	hist_t       word_hist [MAX_WORDS];
	int unsigned n_stored;
	status_t     expected_status_q [$];
	word_t       known_words [$];
	int unsigned n_letters;
	int unsigned n_fail;
	int unsigned status_seen [4];
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_cycles;
	status_t     exp_status;

	anagram_dictionary_lookup_top #(
		.MAX_WORDS (MAX_WORDS),
		.COUNT_BITS(COUNT_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.letter     (letter),
		.last_letter(last_letter),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** anagram_dictionary_lookup_top: FAILED **");
		$finish;
	end

	function automatic void count_letter(bit rt, letter_t l, bit last);
		status_t st;
		if (l < ALPHABET && letter_hist[l] != COUNT_MAX)
			letter_hist[l]++;
		n_letters++;
		if (!last)
			return;
		if (rt == REQ_QUERY) begin
			st = ST_NO_MATCH;
			for (int w = 0; w < n_stored; w++)
				if (word_hist[w] == letter_hist)
					st = ST_MATCH;
		end else if (n_stored >= MAX_WORDS) begin
			st = ST_FULL;
		end else begin
			word_hist[n_stored] = letter_hist;
			n_stored++;
			st = ST_STORED;
		end
		expected_status_q.push_back(st);
		letter_hist = '0;
	endfunction

	function automatic letter_t random_letter();
		if ($urandom_range(99) < 6)
			return letter_t'($urandom_range(31, ALPHABET));
		return letter_t'($urandom_range(ALPHABET - 1));
	endfunction

	function automatic word_t random_word(int max_len);
		word_t wd;
		wd.n = $urandom_range(max_len, 1);
		for (int i = 0; i < WORD_MAX; i++)
			wd.l[i] = random_letter();
		return wd;
	endfunction

	function automatic word_t anagram_of(word_t wd, bit mutate);
		letter_t t;
		int      j;
		for (int i = wd.n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = wd.l[i];
			wd.l[i] = wd.l[j];
			wd.l[j] = t;
		end
		if (mutate)
			wd.l[$urandom_range(wd.n - 1)] = random_letter();
		return wd;
	endfunction

	// returns at the accepting edge; the next call replaces the letter or drops valid, finish_run drops it
	task automatic send_letter(input bit rt, input letter_t l, input bit last);
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		req_type    <= rt;
		letter      <= l;
		last_letter <= last;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		count_letter(rt, l, last);
	endtask

	task automatic send_word(input word_t wd, input bit rt, input bit mixed);
		bit lrt;
		for (int i = 0; i < wd.n; i++) begin
			lrt = (mixed && i != wd.n - 1) ? bit'($urandom_range(1)) : rt;
			send_letter(lrt, wd.l[i], i == wd.n - 1);
		end
	endtask

	task automatic send_random_word(input int max_len, input int unsigned query_pct);
		word_t wd;
		bit    mixed;
		mixed = ($urandom_range(99) < 10);
		if ($urandom_range(99) < query_pct) begin
			if (known_words.size() != 0 && $urandom_range(99) < 70)
				wd = anagram_of(known_words[$urandom_range(known_words.size() - 1)],
					$urandom_range(99) < 25);
			else
				wd = random_word(max_len);
			send_word(wd, REQ_QUERY, mixed);
		end else begin
			wd = random_word(max_len);
			send_word(wd, REQ_DICT, mixed);
			known_words.push_back(wd);
		end
	endtask

	task automatic test_directed_cases();
		send_letter(REQ_QUERY, 5'd0, 1'b1);
		send_letter(REQ_DICT, 5'd25, 1'b1);
		send_letter(REQ_QUERY, 5'd25, 1'b1);
		send_letter(REQ_DICT, 5'd26, 1'b0);
		send_letter(REQ_DICT, 5'd31, 1'b0);
		send_letter(REQ_DICT, 5'd1, 1'b1);
		send_letter(REQ_QUERY, 5'd30, 1'b0);
		send_letter(REQ_QUERY, 5'd1, 1'b1);
		send_letter(REQ_DICT, 5'd25, 1'b1);
		send_letter(REQ_DICT, 5'd27, 1'b1);
		send_letter(REQ_QUERY, 5'd31, 1'b1);
		send_letter(REQ_QUERY, 5'd0, 1'b0);
		send_letter(REQ_DICT, 5'd1, 1'b0);
		send_letter(REQ_QUERY, 5'd2, 1'b1);
		send_letter(REQ_QUERY, 5'd2, 1'b0);
		send_letter(REQ_QUERY, 5'd0, 1'b0);
		send_letter(REQ_DICT, 5'd1, 1'b1);
		send_letter(REQ_DICT, 5'd1, 1'b0);
		send_letter(REQ_DICT, 5'd2, 1'b0);
		send_letter(REQ_QUERY, 5'd0, 1'b1);
		send_letter(REQ_QUERY, 5'd25, 1'b0);
		send_letter(REQ_QUERY, 5'd25, 1'b1);
	endtask

	task automatic test_random_words(input int unsigned n_items, input int unsigned query_pct);
		int unsigned start;
		start = n_letters;
		while (n_letters - start < n_items)
			send_random_word(5, query_pct);
	endtask

	task automatic test_output_backpressure();
		hold_cycles = 200;
		for (int i = 0; i < 16; i++)
			send_random_word(2, 50);
	endtask

	task automatic test_count_saturation();
		for (int i = 0; i < 65; i++)
			send_letter(REQ_DICT, 5'd2, i == 64);
		for (int i = 0; i < 63; i++)
			send_letter(REQ_QUERY, 5'd2, i == 62);
		for (int i = 0; i < 62; i++)
			send_letter(REQ_QUERY, 5'd2, i == 61);
	endtask

	task automatic test_table_full();
		word_t wd;
		while (n_stored < MAX_WORDS) begin
			wd = random_word(2);
			send_word(wd, REQ_DICT, 1'b0);
			known_words.push_back(wd);
		end
		for (int i = 0; i < 4; i++)
			send_word(random_word(3), REQ_DICT, i == 3);
		for (int i = 0; i < 6; i++)
			send_word(anagram_of(known_words[$urandom_range(known_words.size() - 1)], 1'b0),
				REQ_QUERY, 1'b0);
		send_letter(REQ_QUERY, 5'd28, 1'b1);
	endtask

	task automatic finish_run();
		int unsigned waited;
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (expected_status_q.size() != 0 && waited < 200_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (MAX_WORDS + 8) @(posedge clk);
		if (expected_status_q.size() != 0) begin
			$error("status: %0d expected transactions never arrived", expected_status_q.size());
			n_fail++;
		end
		$display("Sent %0d letters; %0d words stored, %0d dropped on a full table,",
			n_letters, status_seen[ST_STORED], status_seen[ST_FULL]);
		$display("%0d queries matched and %0d missed, incl. saturated counts and stalls.",
			status_seen[ST_MATCH], status_seen[ST_NO_MATCH]);
		if (n_fail == 0)
			$display("** anagram_dictionary_lookup_top: PASSED **");
		else
			$display("** anagram_dictionary_lookup_top: FAILED **");
		$finish;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_status_q.size() == 0) begin
				$error("status: expected none, actual %0d", status);
				n_fail++;
			end else begin
				exp_status = expected_status_q.pop_front();
				status_seen[exp_status]++;
				if (status !== exp_status) begin
					$error("status: expected %0d, actual %0d", exp_status, status);
					n_fail++;
				end
			end
		end
	end

	initial begin
		letter_hist    = '0;
		n_stored       = 0;
		n_letters      = 0;
		n_fail         = 0;
		hold_cycles    = 0;
		status_seen    = '{default: 0};
		send_gap_pct   = 8;
		recv_stall_pct = 57;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_words(100, 35);
		test_output_backpressure();

		send_gap_pct   = 57;
		recv_stall_pct = 8;
		test_count_saturation();
		test_random_words(80, 40);

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_table_full();
		test_random_words(60, 50);

		finish_run();
	end

endmodule

// ===== filelist.f =====
rtl/core/adl_pkg.sv
rtl/core/adl_ram.sv
rtl/core/anagram_dictionary_lookup_top.sv
verif/tb.sv
